// File: sv/ttd_pkg.sv
package ttd_pkg;

    localparam int SAMPLE_DEPTH_DEF = 4096;
    localparam int SAMPLE_BITS_DEF  = 16;

    localparam int TH_W    = 16;
    localparam int STEP_W  = 32;
    localparam int LIM_W   = 16;
    localparam int ARR_W   = 13;
    localparam int INT_W   = 28;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Q32.16 products of a 16-bit tick and a 32-bit Q16.16 ratio
    localparam int POS_W  = LIM_W + STEP_W;
    localparam int FRAC_W = 16;

    typedef enum logic [2:0] {
        REG_THRESHOLD        = 3'd0,
        REG_ABS_COMPARE      = 3'd1,
        REG_CLOCK1_STEP      = 3'd2,
        REG_CLOCK2_STEP      = 3'd3,
        REG_CLOCK1_TO_CLOCK2 = 3'd4,
        REG_TS1_LIMIT        = 3'd5,
        REG_TS2_LIMIT        = 3'd6,
        REG_ARRIVAL_LIMIT    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [TH_W-1:0]  threshold;
        logic                    abs_compare;
        logic [STEP_W-1:0]       clock1_step;
        logic [STEP_W-1:0]       clock2_step;
        logic [STEP_W-1:0]       clock1_to_clock2;
        logic [LIM_W-1:0]        ts1_limit;
        logic [LIM_W-1:0]        ts2_limit;
        logic [ARR_W-1:0]        arrival_limit;
    } t_cfg;

    typedef struct packed {
        logic                    crossed;
        logic [LIM_W-1:0]        ts1_cycles;
        logic [LIM_W-1:0]        ts2_cycles;
        logic                    arrival_crossed;
        logic [ARR_W-1:0]        arrival_index;
        logic signed [INT_W-1:0] integral;
        logic                    range_error;
    } t_result;

endpackage

// File: sv/ttd_stream_if.sv
interface ttd_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface ttd_out_if;
    import ttd_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ttd_cfg_regs.sv
module ttd_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ttd_pkg::PADDR_W-1:0]  paddr,
    input  logic [ttd_pkg::PDATA_W-1:0]  pwdata,
    output logic [ttd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output ttd_pkg::t_cfg                o_cfg
);
    import ttd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold        <= '0;
            r_cfg.abs_compare      <= 1'b0;
            r_cfg.clock1_step      <= STEP_W'(32'h0001_0000);
            r_cfg.clock2_step      <= STEP_W'(32'h0001_0000);
            r_cfg.clock1_to_clock2 <= STEP_W'(32'h0001_0000);
            r_cfg.ts1_limit        <= '0;
            r_cfg.ts2_limit        <= '0;
            r_cfg.arrival_limit    <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_THRESHOLD:        r_cfg.threshold        <= pwdata[TH_W-1:0];
                REG_ABS_COMPARE:      r_cfg.abs_compare      <= pwdata[0];
                REG_CLOCK1_STEP:      r_cfg.clock1_step      <= pwdata[STEP_W-1:0];
                REG_CLOCK2_STEP:      r_cfg.clock2_step      <= pwdata[STEP_W-1:0];
                REG_CLOCK1_TO_CLOCK2: r_cfg.clock1_to_clock2 <= pwdata[STEP_W-1:0];
                REG_TS1_LIMIT:        r_cfg.ts1_limit        <= pwdata[LIM_W-1:0];
                REG_TS2_LIMIT:        r_cfg.ts2_limit        <= pwdata[LIM_W-1:0];
                REG_ARRIVAL_LIMIT:    r_cfg.arrival_limit    <= pwdata[ARR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_THRESHOLD:        prdata = PDATA_W'(r_cfg.threshold);
            REG_ABS_COMPARE:      prdata = PDATA_W'(r_cfg.abs_compare);
            REG_CLOCK1_STEP:      prdata = PDATA_W'(r_cfg.clock1_step);
            REG_CLOCK2_STEP:      prdata = PDATA_W'(r_cfg.clock2_step);
            REG_CLOCK1_TO_CLOCK2: prdata = PDATA_W'(r_cfg.clock1_to_clock2);
            REG_TS1_LIMIT:        prdata = PDATA_W'(r_cfg.ts1_limit);
            REG_TS2_LIMIT:        prdata = PDATA_W'(r_cfg.ts2_limit);
            REG_ARRIVAL_LIMIT:    prdata = PDATA_W'(r_cfg.arrival_limit);
            default:              prdata = '0;
        endcase
    end

endmodule

// File: sv/ttd_engine.sv
module ttd_engine #(
    parameter int SAMPLE_DEPTH = ttd_pkg::SAMPLE_DEPTH_DEF,
    parameter int SAMPLE_BITS  = ttd_pkg::SAMPLE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ttd_pkg::t_cfg i_cfg,
    ttd_in_if.sink        i_in,
    ttd_out_if.source     o_out
);
    import ttd_pkg::*;

    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int CW = $clog2(SAMPLE_DEPTH + 1);
    localparam int VW = ((SAMPLE_BITS > TH_W) ? SAMPLE_BITS : TH_W) + 1;
    localparam int IW = POS_W - FRAC_W;

    typedef enum logic [3:0] {
        S_LOAD, S_T1_RD, S_T1_EV, S_T2_MUL, S_T2_CEIL, S_T2_MUL2,
        S_T2_RD, S_T2_EV, S_AR_RD, S_AR_EV, S_DONE
    } t_state;

    // magnitude compare when polarity is ignored, else direction by threshold sign
    function automatic logic f_above(input logic signed [VW-1:0] v,
                                     input logic signed [VW-1:0] th,
                                     input logic ign);
        logic signed [VW-1:0] mv;
        logic signed [VW-1:0] mt;
        mv = (v < 0) ? -v : v;
        mt = (th < 0) ? -th : th;
        if (ign) return mv > mt;
        return (th > 0) ? (v > th) : (v < th);
    endfunction

    function automatic logic f_below(input logic signed [VW-1:0] v,
                                     input logic signed [VW-1:0] th,
                                     input logic ign);
        logic signed [VW-1:0] mv;
        logic signed [VW-1:0] mt;
        mv = (v < 0) ? -v : v;
        mt = (th < 0) ? -th : th;
        if (ign) return mv < mt;
        return (th > 0) ? (v < th) : (v > th);
    endfunction

    logic signed [SAMPLE_BITS-1:0] mem [SAMPLE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rdata;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic signed [INT_W-1:0] r_sum;
    logic [LIM_W-1:0]      r_k;
    logic [LIM_W-1:0]      r_t;
    logic [ARR_W-1:0]      r_i;
    logic [POS_W-1:0]      r_pos;
    logic                  r_crossed;
    logic                  r_acrossed;
    logic                  r_rerr;
    logic                  r_ovalid;
    t_result               r_res;

    logic                  wr_en;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [IW-1:0]         rd_span;
    logic                  full;
    logic signed [31:0]    sx;
    logic [LIM_W-1:0]      mul_a;
    logic [STEP_W-1:0]     mul_b;
    logic [POS_W-1:0]      mul_p;
    logic [IW:0]           t0;
    logic [IW-1:0]         pos_idx;
    logic                  pos_oob;
    logic                  ar_oob;
    logic signed [VW-1:0]  v_ext;
    logic signed [VW-1:0]  th_ext;
    logic                  above;
    logic                  below;

    assign full    = (r_count == CW'(SAMPLE_DEPTH));
    assign sx      = 32'(i_in.sample);
    assign wr_en   = (r_state == S_LOAD) && i_in.valid && !full;
    assign pos_idx = r_pos[POS_W-1:FRAC_W];
    assign pos_oob = pos_idx >= IW'(r_count);
    assign ar_oob  = IW'(r_i) >= IW'(r_count);
    assign v_ext   = VW'(r_rdata);
    assign th_ext  = VW'(i_cfg.threshold);
    assign above   = f_above(v_ext, th_ext, i_cfg.abs_compare);
    assign below   = f_below(v_ext, th_ext, i_cfg.abs_compare);

    // ceil of the tick-1 product: integer part plus one if any fraction
    assign t0 = {1'b0, pos_idx} + (IW+1)'(|r_pos[FRAC_W-1:0]);

    // one shared multiplier: TS2 start product, then TS2 start position
    assign mul_a = (r_state == S_T2_MUL) ? r_k : r_t;
    assign mul_b = (r_state == S_T2_MUL) ? i_cfg.clock1_to_clock2 : i_cfg.clock2_step;
    assign mul_p = mul_a * mul_b;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_pos[FRAC_W +: AW];
        rd_span = pos_idx;
        case (r_state)
            S_T1_RD: rd_en = (r_k < i_cfg.ts1_limit) && !pos_oob;
            S_T2_RD: rd_en = (r_t < i_cfg.ts2_limit) && !pos_oob;
            S_AR_RD: begin
                rd_en   = (r_i < i_cfg.arrival_limit) && !ar_oob;
                rd_addr = AW'(r_i);
                rd_span = IW'(r_i);
            end
            default: ;
        endcase
    end

    // reads start only after the closing beat, so no write can overlap them
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= i_in.sample;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign i_in.ready  = (r_state == S_LOAD);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // the result state reloads the output register itself
            if (r_ovalid && o_out.ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (i_in.valid) begin
                        if (!full) begin
                            r_count <= r_count + CW'(1);
                            r_sum   <= r_sum + sx[INT_W-1:0];
                        end
                        if (i_in.last) begin
                            r_k        <= '0;
                            r_t        <= '0;
                            r_i        <= '0;
                            r_pos      <= '0;
                            r_crossed  <= 1'b0;
                            r_acrossed <= 1'b0;
                            r_rerr     <= 1'b0;
                            r_state    <= S_T1_RD;
                        end
                    end
                end
                S_T1_RD: begin
                    if (r_k >= i_cfg.ts1_limit) begin
                        r_state <= S_AR_RD;
                    end else if (pos_oob) begin
                        r_rerr  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_T1_EV;
                    end
                end
                S_T1_EV: begin
                    if (above) begin
                        r_crossed <= 1'b1;
                        r_state   <= S_T2_MUL;
                    end else begin
                        r_k     <= r_k + LIM_W'(1);
                        r_pos   <= r_pos + POS_W'(i_cfg.clock1_step);
                        r_state <= S_T1_RD;
                    end
                end
                S_T2_MUL: begin
                    r_pos   <= mul_p;
                    r_state <= S_T2_CEIL;
                end
                S_T2_CEIL: begin
                    if (t0 >= (IW+1)'(i_cfg.ts2_limit)) begin
                        // start already at or past the window end: report it, saturated
                        r_t     <= (|t0[IW:LIM_W]) ? '1 : t0[LIM_W-1:0];
                        r_state <= S_AR_RD;
                    end else begin
                        r_t     <= t0[LIM_W-1:0];
                        r_state <= S_T2_MUL2;
                    end
                end
                S_T2_MUL2: begin
                    r_pos   <= mul_p;
                    r_state <= S_T2_RD;
                end
                S_T2_RD: begin
                    if (r_t >= i_cfg.ts2_limit) begin
                        r_state <= S_AR_RD;
                    end else if (pos_oob) begin
                        r_rerr  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_T2_EV;
                    end
                end
                S_T2_EV: begin
                    if (below) begin
                        r_state <= S_AR_RD;
                    end else begin
                        r_t     <= r_t + LIM_W'(1);
                        r_pos   <= r_pos + POS_W'(i_cfg.clock2_step);
                        r_state <= S_T2_RD;
                    end
                end
                S_AR_RD: begin
                    if (r_i >= i_cfg.arrival_limit) begin
                        r_state <= S_DONE;
                    end else if (ar_oob) begin
                        r_rerr  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_AR_EV;
                    end
                end
                S_AR_EV: begin
                    if (above) begin
                        r_acrossed <= 1'b1;
                        r_state    <= S_DONE;
                    end else begin
                        r_i     <= r_i + ARR_W'(1);
                        r_state <= S_AR_RD;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_res.crossed         <= r_crossed && !r_rerr;
                        r_res.ts1_cycles      <= r_rerr ? '0 : r_k;
                        r_res.ts2_cycles      <= r_rerr ? '0 : r_t;
                        r_res.arrival_crossed <= r_acrossed && !r_rerr;
                        r_res.arrival_index   <= r_rerr ? '0 : r_i;
                        r_res.integral        <= r_sum;
                        r_res.range_error     <= r_rerr;
                        r_ovalid              <= 1'b1;
                        r_count               <= '0;
                        r_sum                 <= '0;
                        r_state               <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SAMPLE_DEPTH))
        else $error("sample count beyond store depth");

    a_read_in_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (rd_span < IW'(r_count)))
        else $error("store read beyond loaded samples");

    a_close_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last) |=> (r_state == S_T1_RD))
        else $error("closing beat did not start the walks");

    a_rerr_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_res.range_error) |->
            (!r_res.crossed && !r_res.arrival_crossed && r_res.ts1_cycles == '0))
        else $error("range error result carries measurements");

    a_no_load_on_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && !o_out.ready) |=> (r_state == S_DONE))
        else $error("result dropped while output stalled");

endmodule

// File: sv/toa_tot_threshold_digitizer_top.sv
// Operation: the pulse is loaded into the store; after the closing beat each walk that runs
//   reads, then evaluates, each tick it visits and ends on its limit, a crossing or a read
//   past the pulse; the TS2 start is a product, a ceiling and, in its window, a position.
// Throughput: one sample per cycle while loading; input stalls through the walks and while a
//   finished result waits behind an unaccepted one.
// Reset: synchronous, active low; clears control, counts, sum and registers; store not cleared.

module toa_tot_threshold_digitizer_top #(
    parameter int SAMPLE_DEPTH = ttd_pkg::SAMPLE_DEPTH_DEF,
    parameter int SAMPLE_BITS  = ttd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ttd_in_if.sink                       i_in,
    ttd_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ttd_pkg::PADDR_W-1:0]  paddr,
    input  logic [ttd_pkg::PDATA_W-1:0]  pwdata,
    output logic [ttd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import ttd_pkg::*;

    // register file drives walk settings; user writes it only while engine idles, unenforced
    t_cfg cfg;

    ttd_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // load the pulse into the store, then walk TS1, TS2 and arrival over it
    ttd_engine #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
